/* design/pidc_pkg.sv */
// pidc_pkg: widths, constants and shared types of the positional pid block
// no dependencies; imported by the channel interfaces, pidc_div10 and the top level
package pidc_pkg;

   // field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 24;
   localparam int DRIVE_W    = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   // internal widths
   localparam int ERR_W   = SAMPLE_W + 1;  // setpoint - measured
   localparam int DIFF_W  = ERR_W + 1;     // err - prior err
   localparam int SUM_W   = LIMIT_W + 1;   // clamped integral
   localparam int ACC_W   = SUM_W + 1;     // integral + err before clamp
   localparam int PROD_W  = GAIN_W + SUM_W; // widest gain product
   localparam int MAG_W   = PROD_W - 1;    // magnitude of a product
   localparam int QUO_W   = 37;            // magnitude / 10
   localparam int TERM_W  = QUO_W + 1;     // signed term
   localparam int TOTAL_W = TERM_W + 2;    // sum of three terms

   // divide by ten: q = (m * RECIP_10) >> RECIP_SHIFT, exact for m < 2**42
   localparam int                RECIP_SHIFT = 44;
   localparam logic [40:0]       RECIP_10    = 41'h1999999999A;
   localparam int                HALF_W      = 20;

   localparam logic signed [TOTAL_W-1:0] DRIVE_MAX = 40'sh00_7FFF_FFFF;
   localparam logic signed [TOTAL_W-1:0] DRIVE_MIN = 40'shFF_8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P_GAIN         = 0,
      CSR_I_GAIN         = 1,
      CSR_D_GAIN         = 2,
      CSR_INTEGRAL_LIMIT = 3
   } csr_index_type;

   // stage enables of one divide-by-ten unit
   typedef struct packed {
      logic abs_en;
      logic part_en;
      logic quo_en;
      logic sign_en;
   } div10_ctl_type;

endpackage

/* design/pidc_ifs.sv */
// pidc_ifs: valid/ready channel interfaces for request, response and csr writes
// depends on pidc_pkg for field widths
interface pidc_req_if;
   import pidc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] setpoint;
   logic signed [SAMPLE_W-1:0] measured;
   modport source (output valid, output setpoint, output measured, input ready);
   modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface pidc_rsp_if;
   import pidc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      drive_saturated;
   modport source (output valid, output drive, output drive_saturated, input ready);
   modport sink   (input valid, input drive, input drive_saturated, output ready);
endinterface

interface pidc_csr_if;
   import pidc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/positional_pid_with_integral_clamp.sv */
// positional_pid_with_integral_clamp: positional pid step with a clamped integral
// the result passes through 7 register stages, from the error stage to the output register
// throughput: one transaction per cycle while the output is taken; every stage has its own
// valid bit, so empty stages keep filling while a finished result waits at the output register
// reset (synchronous, active high): gains, limit, integral, prior error and all
// stage valid bits go to zero; depends on pidc_pkg, pidc_ifs and pidc_div10
module positional_pid_with_integral_clamp (
   input logic        clock,
   input logic        reset,
   pidc_req_if.sink   req_if,
   pidc_rsp_if.source rsp_if,
   pidc_csr_if.sink   csr_if
);
   import pidc_pkg::*;

   // stage numbering
   localparam int NUM_STAGES = 7;
   localparam int ST_ERR  = 0;  // error, clamped integral, difference
   localparam int ST_PROD = 1;  // gain products
   localparam int ST_ABS  = 2;  // divider: magnitude
   localparam int ST_PART = 3;  // divider: partial products
   localparam int ST_QUO  = 4;  // divider: quotient magnitude
   localparam int ST_SIGN = 5;  // divider: signed term
   localparam int ST_OUT  = 6;  // sum, saturation, output register

   localparam int PP_W = GAIN_W + ERR_W;   // p product
   localparam int DP_W = GAIN_W + DIFF_W;  // d product

   // configuration registers
   logic signed [GAIN_W-1:0]  p_gain_ff, p_gain_in;
   logic signed [GAIN_W-1:0]  i_gain_ff, i_gain_in;
   logic signed [GAIN_W-1:0]  d_gain_ff, d_gain_in;
   logic        [LIMIT_W-1:0] integral_limit_ff, integral_limit_in;

   // controller state
   logic signed [ERR_W-1:0] prior_error_ff, prior_error_in;
   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] stage_en;
   logic                  req_accept;

   // stage registers
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [PP_W-1:0]    p_prod_ff, p_prod_in;
   logic signed [PROD_W-1:0]  i_prod_ff, i_prod_in;
   logic signed [DP_W-1:0]    d_prod_ff, d_prod_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic                      sat_ff, sat_in;

   // combinational values
   logic signed [ERR_W-1:0]   err_c;
   logic signed [ACC_W-1:0]   acc_c;
   logic signed [ACC_W-1:0]   lim_c;
   logic signed [ACC_W-1:0]   clamp_c;
   logic signed [TERM_W-1:0]  p_term, i_term, d_term;
   logic signed [TOTAL_W-1:0] total_c;
   div10_ctl_type             div_ctl;

   // stage k moves when it is empty or stage k+1 moves too
   always_comb begin
      stage_en[ST_OUT] = !valid_ff[ST_OUT] || rsp_if.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[ST_ERR] = stage_en[ST_ERR] ? req_if.valid : valid_ff[ST_ERR];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_if.ready = stage_en[ST_ERR];
   assign req_accept   = req_if.valid && stage_en[ST_ERR];

   // csr writes, always ready; unknown indexes are dropped
   assign csr_if.ready = 1'b1;

   always_comb begin
      p_gain_in         = p_gain_ff;
      i_gain_in         = i_gain_ff;
      d_gain_in         = d_gain_ff;
      integral_limit_in = integral_limit_ff;
      if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_P_GAIN:         p_gain_in = csr_if.data[GAIN_W-1:0];
            CSR_I_GAIN:         i_gain_in = csr_if.data[GAIN_W-1:0];
            CSR_D_GAIN:         d_gain_in = csr_if.data[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT: integral_limit_in = csr_if.data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // error stage: error, integral update with clamp, difference to prior error
   always_comb begin
      err_c = ERR_W'(req_if.setpoint) - ERR_W'(req_if.measured);
      acc_c = ACC_W'(error_sum_ff) + ACC_W'(err_c);
      lim_c = $signed({{(ACC_W - LIMIT_W){1'b0}}, integral_limit_ff});
      if (acc_c > lim_c) begin
         clamp_c = lim_c;
      end else if (acc_c < -lim_c) begin
         clamp_c = -lim_c;
      end else begin
         clamp_c = acc_c;
      end

      // state only moves on an accepted transaction
      error_sum_in   = req_accept ? clamp_c[SUM_W-1:0] : error_sum_ff;
      prior_error_in = req_accept ? err_c : prior_error_ff;

      err_in  = stage_en[ST_ERR] ? err_c : err_ff;
      acc_in  = stage_en[ST_ERR] ? clamp_c[SUM_W-1:0] : acc_ff;
      diff_in = stage_en[ST_ERR] ? DIFF_W'(err_c) - DIFF_W'(prior_error_ff) : diff_ff;
   end

   // product stage: one multiplier per term
   always_comb begin
      p_prod_in = stage_en[ST_PROD] ? PP_W'(p_gain_ff) * PP_W'(err_ff) : p_prod_ff;
      i_prod_in = stage_en[ST_PROD] ? PROD_W'(i_gain_ff) * PROD_W'(acc_ff) : i_prod_ff;
      d_prod_in = stage_en[ST_PROD] ? DP_W'(d_gain_ff) * DP_W'(diff_ff) : d_prod_ff;
   end

   // each term divided by ten, toward zero
   assign div_ctl.abs_en  = stage_en[ST_ABS];
   assign div_ctl.part_en = stage_en[ST_PART];
   assign div_ctl.quo_en  = stage_en[ST_QUO];
   assign div_ctl.sign_en = stage_en[ST_SIGN];

   pidc_div10 u_div_p (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (PROD_W'(p_prod_ff)),
      .quotient (p_term)
   );

   pidc_div10 u_div_i (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (i_prod_ff),
      .quotient (i_term)
   );

   pidc_div10 u_div_d (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (PROD_W'(d_prod_ff)),
      .quotient (d_term)
   );

   // output stage: exact sum, then clip to the 32-bit signed range
   always_comb begin
      total_c = TOTAL_W'(p_term) + TOTAL_W'(i_term) + TOTAL_W'(d_term);
      if (stage_en[ST_OUT]) begin
         if (total_c > DRIVE_MAX) begin
            drive_in = DRIVE_MAX[DRIVE_W-1:0];
            sat_in   = 1'b1;
         end else if (total_c < DRIVE_MIN) begin
            drive_in = DRIVE_MIN[DRIVE_W-1:0];
            sat_in   = 1'b1;
         end else begin
            drive_in = total_c[DRIVE_W-1:0];
            sat_in   = 1'b0;
         end
      end else begin
         drive_in = drive_ff;
         sat_in   = sat_ff;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff         <= '0;
         i_gain_ff         <= '0;
         d_gain_ff         <= '0;
         integral_limit_ff <= '0;
         prior_error_ff    <= '0;
         error_sum_ff      <= '0;
         valid_ff          <= '0;
      end else begin
         p_gain_ff         <= p_gain_in;
         i_gain_ff         <= i_gain_in;
         d_gain_ff         <= d_gain_in;
         integral_limit_ff <= integral_limit_in;
         prior_error_ff    <= prior_error_in;
         error_sum_ff      <= error_sum_in;
         valid_ff          <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      acc_ff    <= acc_in;
      diff_ff   <= diff_in;
      p_prod_ff <= p_prod_in;
      i_prod_ff <= i_prod_in;
      d_prod_ff <= d_prod_in;
      drive_ff  <= drive_in;
      sat_ff    <= sat_in;
   end

   assign rsp_if.valid           = valid_ff[ST_OUT];
   assign rsp_if.drive           = drive_ff;
   assign rsp_if.drive_saturated = sat_ff;

endmodule

/* design/pidc_div10.sv */
// pidc_div10: four-stage signed divide by ten, truncating toward zero
// depends on pidc_pkg; stage enables come from the pipeline control of the top level
module pidc_div10 (
   input  logic                                clock,
   input  pidc_pkg::div10_ctl_type             ctl,
   input  logic signed [pidc_pkg::PROD_W-1:0]  dividend,
   output logic signed [pidc_pkg::TERM_W-1:0]  quotient
);
   import pidc_pkg::*;

   localparam int RECIP_W = $bits(RECIP_10);
   localparam int HI_W    = RECIP_W - HALF_W;
   localparam logic [HALF_W-1:0] RECIP_LO = RECIP_10[HALF_W-1:0];
   localparam logic [HI_W-1:0]   RECIP_HI = RECIP_10[RECIP_W-1:HALF_W];
   localparam int LL_W   = 2 * HALF_W;
   localparam int LH_W   = HALF_W + HI_W;
   localparam int MID_W  = LH_W + 1;
   localparam int FULL_W = 2 * HALF_W + LH_W + 1;

   logic              neg_abs_ff, neg_abs_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              neg_part_ff, neg_part_in;
   logic [LL_W-1:0]   ll_ff, ll_in;
   logic [LH_W-1:0]   lh_ff, lh_in;
   logic [LL_W-1:0]   hl_ff, hl_in;
   logic [LH_W-1:0]   hh_ff, hh_in;
   logic              neg_quo_ff, neg_quo_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic signed [TERM_W-1:0] quotient_ff, quotient_in;
   logic [MID_W-1:0]  mid;
   logic [FULL_W-1:0] full;
   logic [TERM_W-1:0] quo_ext;

   always_comb begin
      // stage 1: sign and magnitude
      neg_abs_in = ctl.abs_en ? dividend[PROD_W-1] : neg_abs_ff;
      if (ctl.abs_en) begin
         mag_in = dividend[PROD_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
      end else begin
         mag_in = mag_ff;
      end

      // stage 2: partial products against the reciprocal
      neg_part_in = ctl.part_en ? neg_abs_ff : neg_part_ff;
      ll_in = ctl.part_en ? LL_W'(mag_ff[HALF_W-1:0]) * LL_W'(RECIP_LO) : ll_ff;
      lh_in = ctl.part_en ? LH_W'(mag_ff[HALF_W-1:0]) * LH_W'(RECIP_HI) : lh_ff;
      hl_in = ctl.part_en ? LL_W'(mag_ff[MAG_W-1:HALF_W]) * LL_W'(RECIP_LO) : hl_ff;
      hh_in = ctl.part_en ? LH_W'(mag_ff[MAG_W-1:HALF_W]) * LH_W'(RECIP_HI) : hh_ff;

      // stage 3: recombine and shift down
      mid  = MID_W'(lh_ff) + MID_W'(hl_ff);
      full = (FULL_W'(hh_ff) << (2 * HALF_W)) + (FULL_W'(mid) << HALF_W) + FULL_W'(ll_ff);
      neg_quo_in = ctl.quo_en ? neg_part_ff : neg_quo_ff;
      quo_in     = ctl.quo_en ? full[RECIP_SHIFT +: QUO_W] : quo_ff;

      // stage 4: restore sign
      quo_ext = {1'b0, quo_ff};
      if (ctl.sign_en) begin
         quotient_in = neg_quo_ff ? -$signed(quo_ext) : $signed(quo_ext);
      end else begin
         quotient_in = quotient_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg_abs_ff  <= neg_abs_in;
      mag_ff      <= mag_in;
      neg_part_ff <= neg_part_in;
      ll_ff       <= ll_in;
      lh_ff       <= lh_in;
      hl_ff       <= hl_in;
      hh_ff       <= hh_in;
      neg_quo_ff  <= neg_quo_in;
      quo_ff      <= quo_in;
      quotient_ff <= quotient_in;
   end

   assign quotient = quotient_ff;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking regression of the positional pid block with integral clamp
// needs pidc_pkg, pidc_ifs and the block itself; predicts every drive in the bench
module testbench;
   import pidc_pkg::*;

   // run shape
   localparam int     PHASES          = 13;
   localparam int     ITEMS_PER_PHASE = 50;
   localparam int     STEADY_PHASE    = 6;     // no idling on either side here
   localparam int     IDLE_PCT        = 24;
   localparam int     DRAIN_CYCLES    = 8;     // output latency plus margin
   localparam int     RUN_LIMIT_NS    = 2_000_000;
   localparam int     PLAN_ROWS       = 37;
   localparam longint TENTHS          = 10;
   localparam longint DRIVE_HI        = longint'(DRIVE_MAX);
   localparam longint DRIVE_LO        = longint'(DRIVE_MIN);

   // register indexes the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 4'd15;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_type;
   typedef enum int {MIX_NOISE, MIX_TRACK, MIX_WINDUP} sample_mix_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      sat;
   } drive_result_type;

   // one row of the directed plan: a register write or a control step,
   // with the drive typed in only where it is obvious
   typedef struct {
      row_kind_type               kind;
      logic [CSR_IDX_W-1:0]       idx;
      logic [CSR_DATA_W-1:0]      data;
      logic signed [SAMPLE_W-1:0] sp;
      logic signed [SAMPLE_W-1:0] ms;
      bit                         typed;
      logic signed [DRIVE_W-1:0]  drive;
      logic                       sat;
   } plan_row_type;

   logic clock;
   logic reset;

   pidc_req_if req_ch ();
   pidc_rsp_if rsp_ch ();
   pidc_csr_if csr_ch ();

   positional_pid_with_integral_clamp i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source),
      .csr_if (csr_ch.sink)
   );

   // predictor copy of the configuration and the controller state
   logic signed [GAIN_W-1:0]  gain_p;
   logic signed [GAIN_W-1:0]  gain_i;
   logic signed [GAIN_W-1:0]  gain_d;
   logic [LIMIT_W-1:0]        integ_limit;
   logic signed [ERR_W-1:0]   last_err;
   logic signed [SUM_W-1:0]   integ;

   // drives predicted for accepted transactions, oldest first
   drive_result_type pending_drive_q[$];

   plan_row_type plan [PLAN_ROWS];

   bit steady;
   bit req_held;
   bit csr_held;
   int errors;
   int n_steps;
   int n_writes;
   int n_checked;
   int n_saturated;
   int n_clamped;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case a handshake hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   // one positional pid step: clamp the integral, three truncated terms, saturate
   function automatic drive_result_type predict_step(input logic signed [SAMPLE_W-1:0] sp,
                                                     input logic signed [SAMPLE_W-1:0] ms);
      longint           err;
      longint           acc;
      longint           lim;
      longint           total;
      drive_result_type res;
      err = longint'(sp) - longint'(ms);
      acc = longint'(integ) + err;
      lim = longint'(integ_limit);
      // anti-windup clamp
      if (acc > lim || acc < -lim) n_clamped++;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      // each term truncates toward zero on its own
      total = longint'(gain_p) * err / TENTHS
            + longint'(gain_i) * acc / TENTHS
            + longint'(gain_d) * (err - longint'(last_err)) / TENTHS;
      res.sat = 1'b0;
      if (total > DRIVE_HI) begin
         total   = DRIVE_HI;
         res.sat = 1'b1;
      end else if (total < DRIVE_LO) begin
         total   = DRIVE_LO;
         res.sat = 1'b1;
      end
      if (res.sat) n_saturated++;
      res.drive = DRIVE_W'(total);
      integ     = SUM_W'(acc);
      last_err  = ERR_W'(err);
      return res;
   endfunction

   // random gain: full 24-bit word (upper byte dropped by the block) or a small value
   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      if ($urandom_range(1) == 0) return CSR_DATA_W'($urandom);
      return {8'($urandom), 16'($urandom_range(600)) - 16'd300};
   endfunction

   // one control step transaction; the sender may idle first
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sp,
                              input logic signed [SAMPLE_W-1:0] ms,
                              input bit                         typed,
                              input logic signed [DRIVE_W-1:0]  drive,
                              input logic                       sat);
      drive_result_type res;
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.setpoint <= sp;
      req_ch.measured <= ms;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      res = predict_step(sp, ms);
      // a typed-in row overrides the prediction, the state still advances
      if (typed) begin
         res.drive = drive;
         res.sat   = sat;
      end
      pending_drive_q.push_back(res);
      n_steps++;
   endtask

   // register write transaction; the predictor takes it at the accepting edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      csr_held = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_P_GAIN:         gain_p      = data[GAIN_W-1:0];
         CSR_I_GAIN:         gain_i      = data[GAIN_W-1:0];
         CSR_D_GAIN:         gain_d      = data[GAIN_W-1:0];
         CSR_INTEGRAL_LIMIT: integ_limit = data[LIMIT_W-1:0];
         default: ;  // spare indexes change nothing
      endcase
      n_writes++;
   endtask

   // stop sending and wait until every predicted drive has come back
   task automatic enter_config();
      if (req_held) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         req_held = 1'b0;
      end
      while (pending_drive_q.size() != 0) @(posedge clock);
   endtask

   task automatic enter_run();
      if (csr_held) begin
         @(negedge clock);
         csr_ch.valid <= 1'b0;
         csr_held = 1'b0;
      end
   endtask

   // result side stalls at random, except in the steady stretch
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_drive_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got drive %0d sat %0b",
                     $time, rsp_ch.drive, rsp_ch.drive_saturated);
         end else begin
            want = pending_drive_q.pop_front();
            n_checked++;
            if (rsp_ch.drive !== want.drive) begin
               errors++;
               $display("%0t: drive mismatch, expected %0d, got %0d",
                        $time, want.drive, rsp_ch.drive);
            end
            if (rsp_ch.drive_saturated !== want.sat) begin
               errors++;
               $display("%0t: drive_saturated mismatch, expected %0b, got %0b",
                        $time, want.sat, rsp_ch.drive_saturated);
            end
         end
      end
   end

   initial begin : stimulus
      int                         ph;
      int                         k;
      sample_mix_type             mix;
      logic signed [SAMPLE_W-1:0] sp;
      logic signed [SAMPLE_W-1:0] ms;
      logic signed [SAMPLE_W-1:0] base;
      logic [CSR_DATA_W-1:0]      lim;

      // request and csr inputs known from time zero; result ready follows
      // at the first falling edge, well inside reset
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.setpoint = '0;
      req_ch.measured = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = '0;
      csr_ch.data     = '0;
      steady          = 1'b0;

      // predictor matches the reset state
      gain_p      = '0;
      gain_i      = '0;
      gain_d      = '0;
      integ_limit = '0;
      last_err    = '0;
      integ       = '0;

      plan = '{
         // gains at reset: any error gives zero drive
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1, 32'sd0, 1'b0},
         '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 1, 32'sd0, 1'b0},
         // zero limit keeps the integral at zero; the d gain word carries junk up top
         '{ROW_WRITE, CSR_P_GAIN, 24'h007FFF, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_I_GAIN, 24'h000014, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_D_GAIN, 24'hFF8000, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_INTEGRAL_LIMIT, 24'h000000, '0, '0, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sd100, -16'sd100, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sd0, 16'sd0, 0, '0, '0},
         // full limit, max gains, spare indexes must be dropped
         '{ROW_WRITE, CSR_INTEGRAL_LIMIT, 24'hFFFFFF, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_P_GAIN, 24'h007FFF, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_I_GAIN, 24'h007FFF, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_D_GAIN, 24'h007FFF, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_SPARE_LO, 24'hFFFFFF, '0, '0, 0, '0, '0},
         '{ROW_WRITE, CSR_SPARE_HI, 24'hFFFFFF, '0, '0, 0, '0, '0},
         // integral winds up until the sum clips high from the tenth step on
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1, 32'sh7FFF_FFFF, 1'b1},
         '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1, 32'sh7FFF_FFFF, 1'b1},
         // most negative i gain on the wound-up integral clips low
         '{ROW_WRITE, CSR_I_GAIN, 24'h008000, '0, '0, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sd0, 16'sd0, 1, 32'sh8000_0000, 1'b1},
         '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 0, '0, '0},
         // tight clamp of one pulls the large integral straight back
         '{ROW_WRITE, CSR_INTEGRAL_LIMIT, 24'h000001, '0, '0, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, 16'sd5, -16'sd5, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, -16'sd5, 16'sd5, 0, '0, '0},
         '{ROW_SAMPLE, '0, '0, -16'sd1, 16'sd0, 0, '0, '0}
      };

      // synchronous reset, released at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (plan[r].kind == ROW_WRITE) begin
            enter_config();
            write_reg(plan[r].idx, plan[r].data);
         end else begin
            enter_run();
            send_sample(plan[r].sp, plan[r].ms, plan[r].typed, plan[r].drive, plan[r].sat);
         end
      end

      // random part: new settings per phase, state carried across phases
      for (ph = 0; ph < PHASES; ph++) begin
         enter_config();
         if (ph == 0) begin
            // all at the top
            write_reg(CSR_P_GAIN, 24'h007FFF);
            write_reg(CSR_I_GAIN, 24'h007FFF);
            write_reg(CSR_D_GAIN, 24'h007FFF);
            write_reg(CSR_INTEGRAL_LIMIT, 24'hFFFFFF);
         end else if (ph == 1) begin
            // most negative gains, integral held at zero
            write_reg(CSR_P_GAIN, 24'h008000);
            write_reg(CSR_I_GAIN, 24'h008000);
            write_reg(CSR_D_GAIN, 24'h008000);
            write_reg(CSR_INTEGRAL_LIMIT, 24'h000000);
         end else begin
            write_reg(CSR_P_GAIN, pick_gain());
            write_reg(CSR_I_GAIN, pick_gain());
            write_reg(CSR_D_GAIN, pick_gain());
            case ($urandom_range(3))
               0:       lim = '0;
               1:       lim = CSR_DATA_W'($urandom_range(5000));
               2:       lim = CSR_DATA_W'($urandom);
               default: lim = 24'hFFFFFF;
            endcase
            write_reg(CSR_INTEGRAL_LIMIT, lim);
         end
         if ($urandom_range(1) == 1)
            write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)),
                      CSR_DATA_W'($urandom));
         enter_run();

         steady = (ph == STEADY_PHASE);
         mix    = sample_mix_type'($urandom_range(2));
         base   = SAMPLE_W'($urandom);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            case (mix)
               MIX_NOISE: begin
                  sp = SAMPLE_W'($urandom);
                  ms = SAMPLE_W'($urandom);
               end
               MIX_TRACK: begin
                  // small error around a slowly moving target
                  sp = base;
                  ms = base + SAMPLE_W'($urandom_range(128)) - 16'sd64;
                  if ($urandom_range(9) == 0) base = SAMPLE_W'($urandom);
               end
               default: begin
                  // sustained error one way, then the other, to hit the clamp
                  if (k < ITEMS_PER_PHASE / 2) begin
                     sp = SAMPLE_W'(20000 + $urandom_range(12767));
                     ms = SAMPLE_W'(-20000 - int'($urandom_range(12768)));
                  end else begin
                     sp = SAMPLE_W'(-20000 - int'($urandom_range(12768)));
                     ms = SAMPLE_W'(20000 + $urandom_range(12767));
                  end
               end
            endcase
            send_sample(sp, ms, 1'b0, '0, 1'b0);
         end
         steady = 1'b0;
      end

      // drain, then watch for stray results
      enter_config();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d control steps (%0d checked) over %0d register writes",
               n_steps, n_checked, n_writes);
      $display("saturated drives: %0d, clamped integral steps: %0d", n_saturated, n_clamped);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
